FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted min-priority queue.
// Operation and status codes, default depth and controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned QueueDepthDefault = 8;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountOutW = 4;

  localparam logic OpEnqueue = 1'b0;
  localparam logic OpDequeue = 1'b1;

  localparam logic [StatusW-1:0] StatusDone  = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  localparam logic signed [ValueW-1:0] EmptyValue = -32'sd1;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

FILE: sv/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: handshake controller for the sorted min-priority queue.
// Captures one operation, then commits it once the result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output spq_pkg::dp_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath: sorted store, entry count and result register.
// A row of compare-and-shift cells inserts or removes an entry at commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spq_pkg::dp_cmd_t                    cmd_i,
  input  logic                                op_i,
  input  logic signed [spq_pkg::ValueW-1:0]   value_i,
  output logic [spq_pkg::StatusW-1:0]         status_o,
  output logic signed [spq_pkg::ValueW-1:0]   out_value_o,
  output logic [spq_pkg::CountOutW-1:0]       count_after_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic                               op_q;
  logic signed [spq_pkg::ValueW-1:0]  value_q;
  logic signed [spq_pkg::ValueW-1:0]  store_q [QUEUE_DEPTH];
  logic signed [spq_pkg::ValueW-1:0]  store_d [QUEUE_DEPTH];
  logic [CntW-1:0]                    count_q, count_d;
  logic [QUEUE_DEPTH-1:0]             keep;
  logic                               is_full, is_empty;
  logic [spq_pkg::StatusW-1:0]        status_q, status_d;
  logic signed [spq_pkg::ValueW-1:0]  out_value_q, out_value_d;
  logic [spq_pkg::CountOutW-1:0]      count_after_q;

  assign is_full  = (count_q == CntW'(QUEUE_DEPTH));
  assign is_empty = (count_q == '0);

  // A cell keeps its entry when it is occupied and not greater than the new value.
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    assign keep[k] = (CntW'(k) < count_q) && !(store_q[k] > value_q);

    if (k == 0) begin : g_head
      always_comb begin
        if (op_q == spq_pkg::OpDequeue) begin
          store_d[k] = (QUEUE_DEPTH > 1) ? store_q[1] : store_q[k];
        end else if (keep[k]) begin
          store_d[k] = store_q[k];
        end else begin
          store_d[k] = value_q;
        end
      end
    end else if (k == QUEUE_DEPTH - 1) begin : g_tail
      always_comb begin
        if (op_q == spq_pkg::OpDequeue) begin
          store_d[k] = store_q[k];
        end else if (keep[k]) begin
          store_d[k] = store_q[k];
        end else if (keep[k-1]) begin
          store_d[k] = value_q;
        end else begin
          store_d[k] = store_q[k-1];
        end
      end
    end else begin : g_mid
      always_comb begin
        if (op_q == spq_pkg::OpDequeue) begin
          store_d[k] = store_q[k+1];
        end else if (keep[k]) begin
          store_d[k] = store_q[k];
        end else if (keep[k-1]) begin
          store_d[k] = value_q;
        end else begin
          store_d[k] = store_q[k-1];
        end
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    status_d    = spq_pkg::StatusDone;
    out_value_d = '0;
    if (op_q == spq_pkg::OpEnqueue) begin
      if (is_full) begin
        status_d = spq_pkg::StatusFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d    = spq_pkg::StatusEmpty;
        out_value_d = spq_pkg::EmptyValue;
      end else begin
        out_value_d = store_q[0];
        count_d     = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
    if (cmd_i.commit) begin
      status_q      <= status_d;
      out_value_q   <= out_value_d;
      count_after_q <= spq_pkg::CountOutW'(count_d);
      if (!(op_q == spq_pkg::OpEnqueue && is_full) &&
          !(op_q == spq_pkg::OpDequeue && is_empty)) begin
        for (int unsigned k = 0; k < QUEUE_DEPTH; k++) begin
          store_q[k] <= store_d[k];
        end
      end
    end
  end

  assign status_o      = status_q;
  assign out_value_o   = out_value_q;
  assign count_after_o = count_after_q;

endmodule

FILE: sv/sorted_min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core: bounded min-priority queue, ascending store.
// An operation is captured, then committed once the result register is free;
// the result is registered at that commit. A new operation is not accepted
// until the current one commits; all cells compare and shift in the commit cycle.
// Reset: the entry count and handshake state clear; stored values do not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_min_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic signed [spq_pkg::ValueW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [spq_pkg::StatusW-1:0]         status_o,
  output logic signed [spq_pkg::ValueW-1:0]   out_value_o,
  output logic [spq_pkg::CountOutW-1:0]       count_after_o
);

  spq_pkg::dp_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (op_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .count_after_o (count_after_o)
  );

endmodule
